### rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// tcw_pkg: shared types and constants of the text console writer.
// Used by the interfaces, the sequencer and the top level.
package tcw_pkg;

    localparam int MODE_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int LOC_W      = 11;
    localparam int CELL_W     = 16;
    localparam int COLOUR_W   = 8;

    localparam logic [CHAR_W-1:0]   CHAR_TAB        = 8'd9;
    localparam logic [CHAR_W-1:0]   CHAR_LF         = 8'd10;
    localparam logic [CHAR_W-1:0]   CHAR_CR         = 8'd13;
    localparam logic [CHAR_W-1:0]   CHAR_FIRST      = 8'd32;
    localparam logic [CHAR_W-1:0]   CHAR_LAST       = 8'd127;
    localparam logic [CHAR_W-1:0]   CHAR_BLANK      = 8'd32;
    localparam logic [COLOUR_W-1:0] COLOUR_RESET    = 8'd15;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_GOTO  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_PLACE,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_READ,
        ST_READ_DATA,
        ST_LOCATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        mode_t             mode;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [LOC_W-1:0]  cursor_location;
        logic [CELL_W-1:0] cell_value;
    } result_t;

endpackage

### rtl/tcw_if.sv
`timescale 1ns / 1ps
// tcw_request_if and tcw_response_if: valid/ready channels of the console.
// Depends on tcw_pkg for field widths.
interface tcw_request_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::MODE_W-1:0]    mode;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::COL_W-1:0]     col;
    logic [tcw_pkg::ROW_W-1:0]     row;

    modport source (output valid, output mode, output char_code, output col, output row,
                    input ready);
    modport sink   (input valid, input mode, input char_code, input col, input row,
                    output ready);
endinterface

interface tcw_response_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::COL_W-1:0]     cursor_col;
    logic [tcw_pkg::ROW_W-1:0]     cursor_row;
    logic [tcw_pkg::LOC_W-1:0]     cursor_location;
    logic [tcw_pkg::CELL_W-1:0]    cell_value;

    modport source (output valid, output cursor_col, output cursor_row,
                    output cursor_location, output cell_value, input ready);
    modport sink   (input valid, input cursor_col, input cursor_row,
                    input cursor_location, input cell_value, output ready);
endinterface

### rtl/tcw_ram.sv
`timescale 1ns / 1ps
// tcw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/tcw_seq.sv
`timescale 1ns / 1ps
// tcw_seq: sequencer of the console with the shared address unit and cursor.
// Depends on tcw_pkg; drives the ports of one tcw_ram.
module tcw_seq #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 8,
    parameter int CELLS    = COLUMNS * ROWS,
    parameter int ADDR_W   = $clog2(CELLS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_accept,
    input  tcw_pkg::item_t                  item,
    input  logic [tcw_pkg::COLOUR_W-1:0]    colour,
    output logic                            idle,
    output logic                            res_valid,
    input  logic                            res_ready,
    output tcw_pkg::result_t                res,
    output logic                            mem_we,
    output logic [ADDR_W-1:0]               mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]      mem_wdata,
    output logic [ADDR_W-1:0]               mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]      mem_rdata
);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELLS - COLUMNS);

    tcw_pkg::state_t                state_reg, state_next;
    logic [ADDR_W-1:0]              idx_reg, idx_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]              pend_addr_reg, pend_addr_next;
    tcw_pkg::item_t                 item_reg, item_next;
    logic [7:0]                     nx_reg, nx_next;
    logic [5:0]                     ny_reg, ny_next;
    logic [tcw_pkg::COL_W-1:0]      cur_x_reg, cur_x_next;
    logic [tcw_pkg::ROW_W-1:0]      cur_y_reg, cur_y_next;
    logic [ADDR_W-1:0]              loc_reg, loc_next;
    logic [tcw_pkg::CELL_W-1:0]     cell_reg, cell_next;

    logic [tcw_pkg::COL_W-1:0]      unit_x;
    logic [tcw_pkg::ROW_W-1:0]      unit_y;
    logic [ADDR_W-1:0]              unit_addr;
    logic                           printable;
    logic                           is_tab;
    logic                           is_lf;
    logic                           is_cr;
    logic                           pos_ok;
    logic                           wrap;
    logic [5:0]                     wrap_y;
    logic                           scroll;
    logic                           idx_last;
    logic [tcw_pkg::CELL_W-1:0]     blank;

    assign printable = (item_reg.char_code >= tcw_pkg::CHAR_FIRST)
                    && (item_reg.char_code <= tcw_pkg::CHAR_LAST);
    assign is_tab    = item_reg.char_code == tcw_pkg::CHAR_TAB;
    assign is_lf     = item_reg.char_code == tcw_pkg::CHAR_LF;
    assign is_cr     = item_reg.char_code == tcw_pkg::CHAR_CR;
    assign pos_ok    = ({1'b0, item_reg.col} < 8'(COLUMNS)) && ({1'b0, item_reg.row} < 6'(ROWS));
    assign wrap      = nx_reg >= 8'(COLUMNS);
    assign wrap_y    = wrap ? ny_reg + 6'd1 : ny_reg;
    assign scroll    = wrap_y >= 6'(ROWS);
    assign idx_last  = idx_reg == LAST_CELL;
    assign blank     = {colour, tcw_pkg::CHAR_BLANK};

    // Shared address unit: row * COLUMNS + column.
    assign unit_addr = ADDR_W'(unit_y) * ADDR_W'(COLUMNS) + ADDR_W'(unit_x);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                if (idx_last)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = tcw_pkg::ST_DECODE;
                end
            end
            tcw_pkg::ST_DECODE:
            begin
                unique case (item_reg.mode)
                    tcw_pkg::MODE_WRITE:
                        state_next = (printable || is_tab || is_lf || is_cr)
                                   ? tcw_pkg::ST_PLACE : tcw_pkg::ST_FINISH;
                    tcw_pkg::MODE_GOTO:
                        state_next = pos_ok ? tcw_pkg::ST_PLACE : tcw_pkg::ST_FINISH;
                    tcw_pkg::MODE_CLEAR:
                        state_next = tcw_pkg::ST_CLEAR;
                    tcw_pkg::MODE_READ:
                        state_next = pos_ok ? tcw_pkg::ST_READ : tcw_pkg::ST_FINISH;
                    default:
                        state_next = tcw_pkg::ST_FINISH;
                endcase
            end
            tcw_pkg::ST_PLACE:
                state_next = scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_LOCATE;
            tcw_pkg::ST_SCROLL:
            begin
                if (idx_reg == SCROLL_END)
                begin
                    state_next = tcw_pkg::ST_BLANK;
                end
            end
            tcw_pkg::ST_BLANK,
            tcw_pkg::ST_CLEAR:
            begin
                if (idx_last)
                begin
                    state_next = tcw_pkg::ST_LOCATE;
                end
            end
            tcw_pkg::ST_READ:
                state_next = tcw_pkg::ST_READ_DATA;
            tcw_pkg::ST_READ_DATA:
                state_next = tcw_pkg::ST_FINISH;
            tcw_pkg::ST_LOCATE:
                state_next = tcw_pkg::ST_FINISH;
            tcw_pkg::ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        item_next       = item_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        loc_next        = loc_reg;
        cell_next       = cell_reg;
        unit_x          = cur_x_reg;
        unit_y          = cur_y_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = blank;
        mem_raddr       = idx_reg;
        idle            = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                idx_next  = idx_reg + 1'b1;
            end
            tcw_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (item_accept)
                begin
                    item_next = item;
                end
            end
            tcw_pkg::ST_DECODE:
            begin
                cell_next = '0;
                idx_next  = '0;
                nx_next   = {1'b0, cur_x_reg};
                ny_next   = {1'b0, cur_y_reg};
                unique case (item_reg.mode)
                    tcw_pkg::MODE_WRITE:
                    begin
                        if (printable)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = loc_reg;
                            mem_wdata = {colour, item_reg.char_code};
                            nx_next   = {1'b0, cur_x_reg} + 8'd1;
                        end
                        else if (is_tab)
                        begin
                            nx_next = {1'b0, cur_x_reg} + 8'(TAB_STEP);
                        end
                        else if (is_lf)
                        begin
                            nx_next = '0;
                            ny_next = {1'b0, cur_y_reg} + 6'd1;
                        end
                        else if (is_cr)
                        begin
                            nx_next = '0;
                        end
                    end
                    tcw_pkg::MODE_GOTO:
                    begin
                        nx_next = {1'b0, item_reg.col};
                        ny_next = {1'b0, item_reg.row};
                    end
                    default:
                    begin
                    end
                endcase
            end
            tcw_pkg::ST_PLACE:
            begin
                cur_x_next      = wrap ? '0 : nx_reg[tcw_pkg::COL_W-1:0];
                cur_y_next      = scroll ? tcw_pkg::ROW_W'(ROWS - 1)
                                         : wrap_y[tcw_pkg::ROW_W-1:0];
                idx_next        = '0;
                pend_valid_next = 1'b0;
            end
            tcw_pkg::ST_SCROLL:
            begin
                // Write back the cell read last cycle, then fetch the one below.
                if (pend_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = mem_rdata;
                end
                if (idx_reg != SCROLL_END)
                begin
                    mem_raddr       = idx_reg + ADDR_W'(COLUMNS);
                    pend_addr_next  = idx_reg;
                    pend_valid_next = 1'b1;
                    idx_next        = idx_reg + 1'b1;
                end
                else
                begin
                    pend_valid_next = 1'b0;
                end
            end
            tcw_pkg::ST_BLANK:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            tcw_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_last)
                begin
                    cur_x_next = '0;
                    cur_y_next = '0;
                end
            end
            tcw_pkg::ST_READ:
            begin
                unit_x    = item_reg.col;
                unit_y    = item_reg.row;
                mem_raddr = unit_addr;
            end
            tcw_pkg::ST_READ_DATA:
                cell_next = mem_rdata;
            tcw_pkg::ST_LOCATE:
                loc_next = unit_addr;
            tcw_pkg::ST_FINISH:
                res_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcw_pkg::ST_INIT;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
            item_reg       <= '0;
            nx_reg         <= '0;
            ny_reg         <= '0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            loc_reg        <= '0;
            cell_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_addr_reg  <= pend_addr_next;
            item_reg       <= item_next;
            nx_reg         <= nx_next;
            ny_reg         <= ny_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            loc_reg        <= loc_next;
            cell_reg       <= cell_next;
        end
    end

    assign res.cursor_col      = cur_x_reg;
    assign res.cursor_row      = cur_y_reg;
    assign res.cursor_location = tcw_pkg::LOC_W'(loc_reg);
    assign res.cell_value      = cell_reg;

endmodule

### rtl/text_console_writer.sv
`timescale 1ns / 1ps
// text_console_writer: text-mode console over a COLUMNS x ROWS store of 16-bit cells.
// Depends on tcw_pkg, tcw_request_if, tcw_response_if, tcw_ram and tcw_seq.
// Ignored bytes and out-of-range goto or read go straight to the result; a write that scrolls
// first moves every row up and blanks the last row, and clear rewrites every cell with blanks.
// One item at a time; the next can be taken from the cycle after the result is handed off.
// Reset: a clearing pass zeroes every cell of the store; no item is taken meanwhile.
module text_console_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tcw_request_if.sink                   request,
    tcw_response_if.source                response,
    input  logic                          cfg_wr_en,
    input  logic [tcw_pkg::COLOUR_W-1:0]  cfg_wr_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [tcw_pkg::COLOUR_W-1:0] colour_reg;
    logic                         out_valid_reg;
    tcw_pkg::result_t             out_data_reg;

    logic                         idle;
    logic                         item_accept;
    tcw_pkg::item_t               item;
    logic                         res_valid;
    logic                         res_ready;
    tcw_pkg::result_t             res;
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]            mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_rdata;

    assign request.ready  = idle;
    assign item_accept    = request.valid && idle;
    assign item.mode      = tcw_pkg::mode_t'(request.mode);
    assign item.char_code = request.char_code;
    assign item.col       = request.col;
    assign item.row       = request.row;
    assign res_ready      = !out_valid_reg || response.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg    <= tcw_pkg::COLOUR_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                colour_reg <= cfg_wr_data;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign response.valid           = out_valid_reg;
    assign response.cursor_col      = out_data_reg.cursor_col;
    assign response.cursor_row      = out_data_reg.cursor_row;
    assign response.cursor_location = out_data_reg.cursor_location;
    assign response.cell_value      = out_data_reg.cell_value;

    tcw_seq #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP),
        .CELLS    (CELLS),
        .ADDR_W   (ADDR_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (item_accept),
        .item        (item),
        .colour      (colour_reg),
        .idle        (idle),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
